// ===== rtl/eaq_pkg.sv =====
// Package for the elevation angle quantizer: payload types, widths and the
// CORDIC arctangent table. No dependencies.
package eaq_pkg;

    localparam int COORD_WIDTH   = 32;
    localparam int CORDIC_STAGES = 16;
    localparam int DIFF_W        = COORD_WIDTH + 1;
    localparam int WORD_W        = 64;
    localparam int GUARD_BITS    = 60 - COORD_WIDTH;
    localparam int ANGLE_FRAC    = 16;
    localparam int ANG_W         = 26;
    localparam int GAIN_FRAC     = 30;
    localparam int HI_W          = WORD_W - GAIN_FRAC;
    localparam int CODE_W        = 8;
    localparam int MAG_W         = CODE_W - 1;
    localparam int TABLE_LEN     = 32;
    localparam logic [GAIN_FRAC-1:0] INV_GAIN_Q30 = 30'd652032874;
    localparam logic signed [ANG_W-1:0] ANGLE_MAX = ANG_W'(127 << ANGLE_FRAC);

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] observer_x;
        logic signed [COORD_WIDTH-1:0] observer_y;
        logic signed [COORD_WIDTH-1:0] observer_z;
        logic signed [COORD_WIDTH-1:0] target_x;
        logic signed [COORD_WIDTH-1:0] target_y;
        logic signed [COORD_WIDTH-1:0] target_z;
    } t_eaq_in;

    typedef struct packed {
        logic signed [CODE_W-1:0] elevation_code;
        logic                     coincident;
    } t_eaq_out;

    // Item data that rides alongside the CORDIC words
    typedef struct packed {
        logic [DIFF_W-1:0] mag_dz;
        logic              dz_neg;
        logic              vertical;
        logic              coincident;
    } t_eaq_side;

    // atan(2^-i), a quarter turn is 127 << ANGLE_FRAC
    function automatic logic signed [ANG_W-1:0] atan_step(input int idx);
        logic signed [ANG_W-1:0] v;
        case (idx)
            0:  v = 26'sd4161536;
            1:  v = 26'sd2456698;
            2:  v = 26'sd1298052;
            3:  v = 26'sd658911;
            4:  v = 26'sd330734;
            5:  v = 26'sd165528;
            6:  v = 26'sd82784;
            7:  v = 26'sd41395;
            8:  v = 26'sd20698;
            9:  v = 26'sd10349;
            10: v = 26'sd5174;
            11: v = 26'sd2587;
            12: v = 26'sd1294;
            13: v = 26'sd647;
            14: v = 26'sd323;
            15: v = 26'sd162;
            16: v = 26'sd81;
            17: v = 26'sd40;
            18: v = 26'sd20;
            19: v = 26'sd10;
            20: v = 26'sd5;
            21: v = 26'sd3;
            22: v = 26'sd1;
            23: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/elevation_angle_quantizer.sv =====
// Elevation angle quantizer, one transfer per cycle unless the output stalls:
// two unrolled CORDIC pipelines with a gain multiply between them, split into
// a multiply register and a sum register; each CORDIC stage is one register.
// The whole pipeline holds while a result waits at the output. Synchronous
// active-low reset clears the valid bits only. Depends on eaq_pkg, eaq_cordic.
module elevation_angle_quantizer import eaq_pkg::*; #(
    parameter int CORDIC_STAGES_P = CORDIC_STAGES
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_eaq_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_ready,
    output t_eaq_out o_out_data
);

    logic w_en;
    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // differences and magnitudes
    logic signed [DIFF_W-1:0] w_dx, w_dy, w_dz;
    logic [DIFF_W-1:0]        w_mx, w_my, w_mz;
    t_eaq_side                n_side0;

    always_comb begin
        w_dx = DIFF_W'(i_in_data.target_x) - DIFF_W'(i_in_data.observer_x);
        w_dy = DIFF_W'(i_in_data.target_y) - DIFF_W'(i_in_data.observer_y);
        w_dz = DIFF_W'(i_in_data.target_z) - DIFF_W'(i_in_data.observer_z);
        w_mx = w_dx[DIFF_W-1] ? DIFF_W'(-w_dx) : DIFF_W'(w_dx);
        w_my = w_dy[DIFF_W-1] ? DIFF_W'(-w_dy) : DIFF_W'(w_dy);
        w_mz = w_dz[DIFF_W-1] ? DIFF_W'(-w_dz) : DIFF_W'(w_dz);
        n_side0.mag_dz     = w_mz;
        n_side0.dz_neg     = w_dz[DIFF_W-1];
        n_side0.vertical   = (w_dx == '0) && (w_dy == '0);
        n_side0.coincident = (w_dx == '0) && (w_dy == '0) && (w_dz == '0);
    end

    logic                     r_v0;
    logic signed [WORD_W-1:0] r_x0, r_y0;
    t_eaq_side                r_side0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (w_en) begin
            r_v0 <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x0    <= WORD_W'(w_mx) << GUARD_BITS;
            r_y0    <= WORD_W'(w_my) << GUARD_BITS;
            r_side0 <= n_side0;
        end
    end

    // horizontal distance, scaled by the CORDIC gain
    logic                     w_v1;
    logic signed [WORD_W-1:0] w_x1;
    t_eaq_side                w_side1;

    eaq_cordic #(.STAGES(CORDIC_STAGES_P)) u_cordic_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v0),
        .i_x     (r_x0),
        .i_y     (r_y0),
        .i_side  (r_side0),
        .o_valid (w_v1),
        .o_x     (w_x1),
        .o_z     (),
        .o_side  (w_side1)
    );

    // remove the gain: split multiply, then sum
    logic                   r_v2;
    logic [WORD_W-1:0]      r_phi;
    logic [WORD_W-1:0]      r_plo;
    t_eaq_side              r_side2;
    logic [HI_W-1:0]        w_hi;
    logic [GAIN_FRAC-1:0]   w_lo;

    assign w_hi = w_x1[WORD_W-1:GAIN_FRAC];
    assign w_lo = w_x1[GAIN_FRAC-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v2 <= w_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_phi   <= WORD_W'(w_hi * INV_GAIN_Q30);
            r_plo   <= WORD_W'(w_lo * INV_GAIN_Q30);
            r_side2 <= w_side1;
        end
    end

    logic                     r_v3;
    logic signed [WORD_W-1:0] r_x3, r_y3;
    t_eaq_side                r_side3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else if (w_en) begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x3    <= r_phi + (r_plo >> GAIN_FRAC);
            r_y3    <= WORD_W'(r_side2.mag_dz) << GUARD_BITS;
            r_side3 <= r_side2;
        end
    end

    // elevation angle
    logic                    w_v4;
    logic signed [ANG_W-1:0] w_z4;
    t_eaq_side               w_side4;

    eaq_cordic #(.STAGES(CORDIC_STAGES_P)) u_cordic_e (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_v3),
        .i_x     (r_x3),
        .i_y     (r_y3),
        .i_side  (r_side3),
        .o_valid (w_v4),
        .o_x     (),
        .o_z     (w_z4),
        .o_side  (w_side4)
    );

    // clamp, quantize, apply sign and the special cases
    logic signed [ANG_W-1:0]  w_zc;
    logic [MAG_W-1:0]         w_mag;
    t_eaq_out                 n_out;

    always_comb begin
        if (w_z4 < 0) begin
            w_zc = '0;
        end else if (w_z4 > ANGLE_MAX) begin
            w_zc = ANGLE_MAX;
        end else begin
            w_zc = w_z4;
        end
        w_mag = w_side4.vertical ? {MAG_W{1'b1}} : w_zc[ANGLE_FRAC+MAG_W-1:ANGLE_FRAC];
        if (w_side4.coincident) begin
            w_mag = '0;
        end
        n_out.elevation_code = w_side4.dz_neg ? -$signed({1'b0, w_mag})
                                              : $signed({1'b0, w_mag});
        n_out.coincident     = w_side4.coincident;
    end

    logic r_ov;
    t_eaq_out r_od;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= w_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_od <= n_out;
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_data  = r_od;

endmodule

// ===== rtl/eaq_cordic.sv =====
// Unrolled CORDIC vectoring pipeline, one rotation per register stage.
// Depends on eaq_pkg.
module eaq_cordic import eaq_pkg::*; #(
    parameter int STAGES = CORDIC_STAGES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  logic signed [WORD_W-1:0] i_x,
    input  logic signed [WORD_W-1:0] i_y,
    input  t_eaq_side                i_side,
    output logic                     o_valid,
    output logic signed [WORD_W-1:0] o_x,
    output logic signed [ANG_W-1:0]  o_z,
    output t_eaq_side                o_side
);

    logic signed [WORD_W-1:0] r_x    [STAGES+1];
    logic signed [WORD_W-1:0] r_y    [STAGES+1];
    logic signed [ANG_W-1:0]  r_z    [STAGES+1];
    t_eaq_side                r_side [STAGES+1];
    logic                     r_valid [STAGES+1];

    // stage 0 is the input itself
    always_comb begin
        r_x[0]     = i_x;
        r_y[0]     = i_y;
        r_z[0]     = '0;
        r_side[0]  = i_side;
        r_valid[0] = i_valid;
    end

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [WORD_W-1:0] n_x;
        logic signed [WORD_W-1:0] n_y;
        logic signed [ANG_W-1:0]  n_z;

        // rotate toward the x axis
        always_comb begin
            if (!r_y[i][WORD_W-1]) begin
                n_x = r_x[i] + (r_y[i] >>> i);
                n_y = r_y[i] - (r_x[i] >>> i);
                n_z = r_z[i] + atan_step(i);
            end else begin
                n_x = r_x[i] - (r_y[i] >>> i);
                n_y = r_y[i] + (r_x[i] >>> i);
                n_z = r_z[i] - atan_step(i);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[i+1] <= 1'b0;
            end else if (i_en) begin
                r_valid[i+1] <= r_valid[i];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[i+1]    <= n_x;
                r_y[i+1]    <= n_y;
                r_z[i+1]    <= n_z;
                r_side[i+1] <= r_side[i];
            end
        end
    end

    assign o_valid = r_valid[STAGES];
    assign o_x     = r_x[STAGES];
    assign o_z     = r_z[STAGES];
    assign o_side  = r_side[STAGES];

endmodule

// ===== rtl/eaq_checker.sv =====
// Port-level checks for the elevation angle quantizer, bound to the top level.
// Depends on eaq_pkg.
module eaq_checker import eaq_pkg::*; (
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     o_in_ready,
    input logic     o_out_valid,
    input logic     i_out_ready,
    input t_eaq_out o_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // the pipeline only stalls on a blocked output
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input blocked without output backpressure");

    // coincident points give a zero code
    a_coin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.coincident |-> o_out_data.elevation_code == '0)
        else $error("coincident with nonzero code");

    // code stays within one quarter turn
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.elevation_code != 8'sh80)
        else $error("code out of range");

    // reset empties the pipeline
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind elevation_angle_quantizer eaq_checker u_eaq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== tb/elevation_angle_quantizer_tb.sv =====
// Testbench for elevation_angle_quantizer: drives point pairs through the
// valid/ready input, predicts each elevation code with a CORDIC model of its own.
// Depends on eaq_pkg and the RTL of the block.
module elevation_angle_quantizer_tb;
    import eaq_pkg::*;

    localparam int PERIOD   = 20;
    localparam int LATENCY  = 2 * CORDIC_STAGES + 4;
    localparam int N_RANDOM = 1330;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_eaq_in  i_in_data;
    logic     o_out_valid;
    logic     i_out_ready;
    t_eaq_out o_out_data;

    t_eaq_out angle_queue[$];
    int       n_errors;
    int       send_idle_pct;
    int       recv_stall_pct;
    bit       sending_done;

    // one directed row: the point pair, and an expected result where obvious
    typedef struct {
        t_eaq_in  pts;
        bit       has_fixed;
        t_eaq_out fixed;
    } t_row;

    elevation_angle_quantizer DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_data  (i_in_data),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(PERIOD * 4000000);
        $display("CHECK FAILED");
        $finish;
    end

    // floor shift right of a signed word
    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    // CORDIC vectoring: rotate (x, y) onto the x axis, sum the angle in acc
    function automatic void rotate_to_axis(inout longint x, inout longint y,
                                           inout longint acc);
        longint xs, ys;
        for (int i = 0; i < CORDIC_STAGES && i < TABLE_LEN; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                acc = acc + longint'(atan_step(i));
            end else begin
                x = x - ys;
                y = y + xs;
                acc = acc - longint'(atan_step(i));
            end
        end
    endfunction

    // expected elevation code and flag for a point pair
    function automatic t_eaq_out elevation_of(t_eaq_in p);
        longint dx, dy, dz, x, y, acc, code;
        logic [63:0] hx, hi, lo, h;
        t_eaq_out r;
        dx = longint'(p.target_x) - longint'(p.observer_x);
        dy = longint'(p.target_y) - longint'(p.observer_y);
        dz = longint'(p.target_z) - longint'(p.observer_z);
        r.coincident = 1'b0;
        if (dx == 0 && dy == 0) begin
            if (dz == 0) begin
                code = 0;
                r.coincident = 1'b1;
            end else begin
                code = (dz > 0) ? 127 : -127;
            end
        end else begin
            x = (dx < 0 ? -dx : dx) <<< GUARD_BITS;
            y = (dy < 0 ? -dy : dy) <<< GUARD_BITS;
            acc = 0;
            rotate_to_axis(x, y, acc);
            hx = x;
            hi = hx >> 30;
            lo = hx & ((64'd1 << 30) - 1);
            h = hi * 64'(INV_GAIN_Q30) + ((lo * 64'(INV_GAIN_Q30)) >> 30);
            x = h;
            y = (dz < 0 ? -dz : dz) <<< GUARD_BITS;
            acc = 0;
            rotate_to_axis(x, y, acc);
            if (acc < 0) acc = 0;
            if (acc > (longint'(127) << ANGLE_FRAC)) acc = longint'(127) << ANGLE_FRAC;
            code = acc >>> ANGLE_FRAC;
            if (dz < 0) code = -code;
        end
        r.elevation_code = code[7:0];
        return r;
    endfunction

    function automatic t_eaq_out fixed_result(int code, bit flag);
        t_eaq_out r;
        r.elevation_code = code[7:0];
        r.coincident = flag;
        return r;
    endfunction

    function automatic t_row make_row(longint ox, longint oy, longint oz,
                                      longint tx, longint ty, longint tz,
                                      bit has_fixed, int code, bit flag);
        t_row r;
        r.pts = '{ox[31:0], oy[31:0], oz[31:0], tx[31:0], ty[31:0], tz[31:0]};
        r.has_fixed = has_fixed;
        r.fixed = fixed_result(code, flag);
        return r;
    endfunction

    // random coordinate: mostly moderate, sometimes extreme or small offsets
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            2: return 32'($signed($urandom_range(0, 64)) - 32);
            default: return 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'sh0080_0000);
        endcase
    endfunction

    function automatic t_eaq_in rand_pair();
        t_eaq_in p;
        p.observer_x = rand_coord();
        p.observer_y = rand_coord();
        p.observer_z = rand_coord();
        p.target_x = rand_coord();
        p.target_y = rand_coord();
        p.target_z = rand_coord();
        case ($urandom_range(0, 11))
            0: begin  // straight up or down
                p.target_x = p.observer_x;
                p.target_y = p.observer_y;
            end
            1: p = '{p.observer_x, p.observer_y, p.observer_z,
                     p.observer_x, p.observer_y, p.observer_z};
            2: p.target_z = p.observer_z;   // horizontal
            3: p.target_x = p.observer_x;   // dx is zero
            default: ;
        endcase
        return p;
    endfunction

    // hand one point pair over, with a random sender gap first; valid drops
    // only in a gap, so back-to-back transfers keep it high
    task automatic send_pair(t_eaq_in p);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // log the expectation on every accepted transfer
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) angle_queue.push_back(elevation_of(i_in_data));
    end

    // compare each accepted result with the oldest expectation
    always @(posedge i_clk) begin
        t_eaq_out exp_r;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (angle_queue.size() == 0) begin
                $display("%0t: unexpected result %p", $time, o_out_data);
                n_errors++;
            end else begin
                exp_r = angle_queue.pop_front();
                if (o_out_data.elevation_code !== exp_r.elevation_code) begin
                    $display("%0t: elevation_code expected %0d actual %0d", $time,
                             exp_r.elevation_code, o_out_data.elevation_code);
                    n_errors++;
                end
                if (o_out_data.coincident !== exp_r.coincident) begin
                    $display("%0t: coincident expected %0b actual %0b", $time,
                             exp_r.coincident, o_out_data.coincident);
                    n_errors++;
                end
            end
        end
    end

    // receiver stalls
    always @(negedge i_clk) begin
        if (sending_done) i_out_ready <= 1'b1;
        else i_out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        t_row rows[$];
        t_eaq_in p;
        int idle_tab[4];
        int stall_tab[4];
        int waited;
        idle_tab = '{0, 81, 0, 27};
        stall_tab = '{0, 0, 81, 27};
        n_errors = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sending_done = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_out_ready = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed rows: coincident, vertical, extremes, octants
        rows.push_back(make_row(0, 0, 0, 0, 0, 0, 1, 0, 1));
        rows.push_back(make_row(-2147483648, 2147483647, -1, -2147483648, 2147483647, -1,
                                1, 0, 1));
        rows.push_back(make_row(5, 5, 0, 5, 5, 1, 1, 127, 0));
        rows.push_back(make_row(5, 5, 0, 5, 5, -1, 1, -127, 0));
        rows.push_back(make_row(0, 0, -2147483648, 0, 0, 2147483647, 1, 127, 0));
        rows.push_back(make_row(0, 0, 2147483647, 0, 0, -2147483648, 1, -127, 0));
        rows.push_back(make_row(0, 0, 0, 65536, 0, 0, 1, 0, 0));
        rows.push_back(make_row(0, 0, 0, 0, -65536, 0, 1, 0, 0));
        rows.push_back(make_row(-2147483648, -2147483648, 0,
                                2147483647, 2147483647, 0, 1, 0, 0));
        rows.push_back(make_row(2147483647, 2147483647, 2147483647,
                                -2147483648, -2147483648, -2147483648, 0, 0, 0));
        rows.push_back(make_row(-2147483648, -2147483648, -2147483648,
                                2147483647, 2147483647, 2147483647, 0, 0, 0));
        rows.push_back(make_row(0, 0, 0, 65536, 0, 65536, 0, 0, 0));
        rows.push_back(make_row(0, 0, 0, 65536, 65536, -65536, 0, 0, 0));
        rows.push_back(make_row(0, 0, 0, 1, 0, 2147483647, 0, 0, 0));
        rows.push_back(make_row(0, 0, 0, 2147483647, 0, 1, 0, 0, 0));
        rows.push_back(make_row(0, 0, 0, -1, -1, -1, 0, 0, 0));
        rows.push_back(make_row(0, 0, 0, 3, -4, 5, 0, 0, 0));
        rows.push_back(make_row(0, 0, 0, -2147483648, 0, 2147483647, 0, 0, 0));
        rows.push_back(make_row(100, -100, 7, -100, 100, -7, 0, 0, 0));
        rows.push_back(make_row(-1, -1, -1, 0, 0, 0, 0, 0, 0));

        foreach (rows[i]) begin
            if (rows[i].has_fixed && elevation_of(rows[i].pts) != rows[i].fixed) begin
                $display("%0t: directed row %0d expected %p predictor %p", $time, i,
                         rows[i].fixed, elevation_of(rows[i].pts));
                n_errors++;
            end
            send_pair(rows[i].pts);
        end

        // random phases with different idling
        for (int ph = 0; ph < 5; ph++) begin
            send_idle_pct = idle_tab[ph % 4];
            recv_stall_pct = stall_tab[ph % 4];
            for (int k = 0; k < N_RANDOM / 5; k++) begin
                p = rand_pair();
                send_pair(p);
            end
            // hold the sender until the pipeline drains
            if (ph == 1) begin
                i_in_valid <= 1'b0;
                while (angle_queue.size() != 0) @(negedge i_clk);
            end
        end

        i_in_valid <= 1'b0;
        sending_done = 1'b1;
        waited = 0;
        while (angle_queue.size() != 0 && waited < 100000) begin
            @(negedge i_clk);
            waited++;
        end
        repeat (LATENCY + 4) @(negedge i_clk);
        if (n_errors == 0 && angle_queue.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
